### src/wels_pkg.sv
// Shared types and constants for the wait event latency statistics table.
// No dependencies.
package wels_pkg;

    localparam int IDX_MAX_W = 6;

    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_END   = 2'd1;
    localparam logic [1:0] CMD_DUMP  = 2'd2;
    localparam logic [1:0] CMD_CLEAR = 2'd3;

    localparam logic [3:0] ST_STARTED   = 4'd0;
    localparam logic [3:0] ST_ZERO_ID   = 4'd1;
    localparam logic [3:0] ST_MISS      = 4'd2;
    localparam logic [3:0] ST_FULL      = 4'd3;
    localparam logic [3:0] ST_ENDED     = 4'd4;
    localparam logic [3:0] ST_NONE_OPEN = 4'd5;
    localparam logic [3:0] ST_ENTRY     = 4'd6;
    localparam logic [3:0] ST_EMPTY     = 4'd7;
    localparam logic [3:0] ST_CLEARED   = 4'd8;

    typedef struct packed {
        logic [31:0] id;
        logic [63:0] count;
        logic [63:0] sum;
        logic [63:0] max;
    } slot_t;

    typedef struct packed {
        logic                 load;
        logic                 srch_clr;
        logic                 rd_en;
        logic                 rd_open;
        logic [IDX_MAX_W-1:0] addr;
        logic                 start_commit;
        logic                 end_commit;
        logic                 dump_emit;
        logic                 simple_emit;
        logic [3:0]           simple_status;
        logic                 clear_tab;
    } ctl_t;

    typedef struct packed {
        logic [1:0] cmd;
        logic       id_zero;
        logic       open_valid;
        logic       valid_at;
        logic       out_busy;
    } stat_t;

endpackage

### src/wels_datapath.sv
// Datapath: slot memory, valid bits, open slot state, search and output register.
// Depends on wels_pkg.
module wels_datapath #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  wels_pkg::ctl_t ctl,
    output wels_pkg::stat_t stat,
    input  logic [103:0]   s_tdata,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [231:0]   m_tdata,
    output logic           m_tlast
);
    import wels_pkg::*;

    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    slot_t mem [TABLE_ENTRIES];
    slot_t rd_reg, work_reg;
    logic [TABLE_ENTRIES-1:0] valid_reg;
    logic [IDX_W-1:0] rd_idx_reg, hit_idx_reg, free_idx_reg, open_slot_reg;
    logic rd_vld_reg, scan_reg, hit_reg, free_reg, open_valid_reg;
    logic [63:0] start_time_reg;
    logic [1:0]  cmd_reg;
    logic [31:0] id_reg;
    logic [63:0] ts_reg;
    logic        no_insert_reg, close_reg;
    logic        out_vld_reg, out_last_reg;
    logic [3:0]  out_status_reg;
    slot_t       out_slot_reg;

    logic [IDX_W-1:0] addr;
    logic [IDX_W-1:0] rd_addr;
    logic [63:0] diff, new_sum, new_max, new_cnt;
    logic        above;
    logic        wr_en;
    logic [IDX_W-1:0] wr_addr;
    slot_t       wr_data;

    assign addr    = ctl.addr[IDX_W-1:0];
    assign rd_addr = ctl.rd_open ? open_slot_reg : addr;
    assign diff    = ts_reg - start_time_reg;
    assign new_sum = rd_reg.sum + diff;
    assign new_max = (rd_reg.max < diff) ? diff : rd_reg.max;
    assign new_cnt = work_reg.count + 64'd1;

    always_comb begin
        above = 1'b0;
        for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (valid_reg[i] && (IDX_W'(i) > rd_idx_reg)) begin
                above = 1'b1;
            end
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = hit_idx_reg;
        wr_data = '{id: work_reg.id, count: new_cnt, sum: work_reg.sum, max: work_reg.max};
        if (ctl.start_commit) begin
            if (hit_reg) begin
                wr_en = 1'b1;
            end else if (!no_insert_reg && free_reg) begin
                wr_en   = 1'b1;
                wr_addr = free_idx_reg;
                wr_data = '{id: id_reg, count: 64'd1, sum: 64'd0, max: 64'd0};
            end
        end else if (ctl.end_commit) begin
            wr_en   = 1'b1;
            wr_addr = rd_idx_reg;
            wr_data = '{id: rd_reg.id, count: rd_reg.count, sum: new_sum, max: new_max};
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en) begin
            rd_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg      <= '0;
            open_valid_reg <= 1'b0;
            open_slot_reg  <= '0;
            start_time_reg <= '0;
            rd_vld_reg     <= 1'b0;
            scan_reg       <= 1'b0;
            hit_reg        <= 1'b0;
            free_reg       <= 1'b0;
            out_vld_reg    <= 1'b0;
        end else begin
            rd_vld_reg <= ctl.rd_en;
            if (ctl.rd_en) begin
                rd_idx_reg <= rd_addr;
            end
            if (ctl.load) begin
                cmd_reg       <= s_tdata[1:0];
                id_reg        <= s_tdata[33:2];
                ts_reg        <= s_tdata[97:34];
                no_insert_reg <= s_tdata[98];
                close_reg     <= s_tdata[99];
            end
            if (ctl.srch_clr) begin
                scan_reg <= 1'b1;
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end else if (scan_reg && rd_vld_reg) begin
                if (valid_reg[rd_idx_reg]) begin
                    if (!hit_reg && rd_reg.id == id_reg) begin
                        hit_reg     <= 1'b1;
                        hit_idx_reg <= rd_idx_reg;
                        work_reg    <= rd_reg;
                    end
                end else if (!free_reg) begin
                    free_reg     <= 1'b1;
                    free_idx_reg <= rd_idx_reg;
                end
            end
            if (m_tvalid && m_tready) begin
                out_vld_reg <= 1'b0;
            end
            if (ctl.start_commit) begin
                scan_reg     <= 1'b0;
                out_vld_reg  <= 1'b1;
                out_last_reg <= 1'b1;
                if (hit_reg) begin
                    open_valid_reg <= 1'b1;
                    open_slot_reg  <= hit_idx_reg;
                    start_time_reg <= ts_reg;
                    out_status_reg <= ST_STARTED;
                    out_slot_reg   <= wr_data;
                end else if (no_insert_reg || !free_reg) begin
                    open_valid_reg <= 1'b0;
                    out_status_reg <= no_insert_reg ? ST_MISS : ST_FULL;
                    out_slot_reg   <= '{id: id_reg, count: 64'd0, sum: 64'd0, max: 64'd0};
                end else begin
                    valid_reg[free_idx_reg] <= 1'b1;
                    open_valid_reg <= 1'b1;
                    open_slot_reg  <= free_idx_reg;
                    start_time_reg <= ts_reg;
                    out_status_reg <= ST_STARTED;
                    out_slot_reg   <= wr_data;
                end
            end
            if (ctl.end_commit) begin
                out_vld_reg    <= 1'b1;
                out_last_reg   <= 1'b1;
                out_status_reg <= ST_ENDED;
                out_slot_reg   <= wr_data;
                if (close_reg) begin
                    open_valid_reg <= 1'b0;
                end
            end
            if (ctl.dump_emit) begin
                out_vld_reg    <= 1'b1;
                out_last_reg   <= !above;
                out_status_reg <= ST_ENTRY;
                out_slot_reg   <= rd_reg;
            end
            if (ctl.simple_emit) begin
                out_vld_reg    <= 1'b1;
                out_last_reg   <= 1'b1;
                out_status_reg <= ctl.simple_status;
                out_slot_reg   <= '0;
            end
            if (ctl.clear_tab) begin
                valid_reg      <= '0;
                open_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.cmd        = cmd_reg;
    assign stat.id_zero    = (id_reg == 32'd0);
    assign stat.open_valid = open_valid_reg;
    assign stat.valid_at   = valid_reg[addr];
    assign stat.out_busy   = out_vld_reg;

    assign m_tvalid = out_vld_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {4'd0, out_slot_reg.max, out_slot_reg.sum, out_slot_reg.count,
                       out_slot_reg.id, out_status_reg};
endmodule

### src/wels_ctrl.sv
// Controller: sequences start search, end update, dump walk and clear.
// Depends on wels_pkg.
module wels_ctrl #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  wels_pkg::stat_t stat,
    output wels_pkg::ctl_t  ctl
);
    import wels_pkg::*;

    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic [3:0] {
        S_IDLE, S_DEC, S_SCAN, S_SRES, S_END_RD, S_END_WR,
        S_DUMP, S_DUMP_RD, S_DUMP_WAIT, S_OUT
    } state_t;

    state_t state_reg;
    logic [CNT_W-1:0] idx_reg;
    logic found_reg;
    logic idx_done;

    assign idx_done = (idx_reg == CNT_W'(TABLE_ENTRIES));
    assign s_tready = (state_reg == S_IDLE);

    always_comb begin
        ctl      = '0;
        ctl.addr = IDX_MAX_W'(idx_reg);
        ctl.load = s_tvalid && s_tready;
        unique case (state_reg)
            S_DEC: begin
                unique case (stat.cmd)
                    CMD_START: begin
                        if (stat.id_zero) begin
                            ctl.simple_emit   = 1'b1;
                            ctl.simple_status = ST_ZERO_ID;
                        end else begin
                            ctl.srch_clr = 1'b1;
                        end
                    end
                    CMD_END: begin
                        if (!stat.open_valid) begin
                            ctl.simple_emit   = 1'b1;
                            ctl.simple_status = ST_NONE_OPEN;
                        end
                    end
                    CMD_DUMP: ;
                    CMD_CLEAR: begin
                        ctl.clear_tab     = 1'b1;
                        ctl.simple_emit   = 1'b1;
                        ctl.simple_status = ST_CLEARED;
                    end
                    default: ;
                endcase
            end
            S_SCAN:    ctl.rd_en = !idx_done;
            S_SRES:    ctl.start_commit = 1'b1;
            S_END_RD: begin
                ctl.rd_en   = 1'b1;
                ctl.rd_open = 1'b1;
            end
            S_END_WR:  ctl.end_commit = 1'b1;
            S_DUMP: begin
                if (idx_done) begin
                    ctl.clear_tab     = 1'b1;
                    ctl.simple_emit   = !found_reg;
                    ctl.simple_status = ST_EMPTY;
                end else begin
                    ctl.rd_en = stat.valid_at;
                end
            end
            S_DUMP_RD: ctl.dump_emit = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
            found_reg <= 1'b0;
        end else begin
            unique case (state_reg)
                S_IDLE: if (s_tvalid) state_reg <= S_DEC;
                S_DEC: begin
                    idx_reg   <= '0;
                    found_reg <= 1'b0;
                    unique case (stat.cmd)
                        CMD_START: state_reg <= stat.id_zero ? S_OUT : S_SCAN;
                        CMD_END:   state_reg <= stat.open_valid ? S_END_RD : S_OUT;
                        CMD_DUMP:  state_reg <= S_DUMP;
                        CMD_CLEAR: state_reg <= S_OUT;
                        default:   state_reg <= S_OUT;
                    endcase
                end
                S_SCAN: begin
                    if (idx_done) begin
                        state_reg <= S_SRES;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_SRES:   state_reg <= S_OUT;
                S_END_RD: state_reg <= S_END_WR;
                S_END_WR: state_reg <= S_OUT;
                S_DUMP: begin
                    if (idx_done) begin
                        state_reg <= found_reg ? S_IDLE : S_OUT;
                    end else if (stat.valid_at) begin
                        state_reg <= S_DUMP_RD;
                    end else begin
                        idx_reg <= idx_reg + 1'b1;
                    end
                end
                S_DUMP_RD: begin
                    found_reg <= 1'b1;
                    state_reg <= S_DUMP_WAIT;
                end
                S_DUMP_WAIT: begin
                    if (!stat.out_busy) begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_DUMP;
                    end
                end
                S_OUT: if (!stat.out_busy) state_reg <= S_IDLE;
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

### src/wait_event_latency_stats_table_top.sv
// Wait event latency statistics table, top level.
// Start: the memory scan reads one slot a cycle, looking for the id or a free slot (id 0 skips it).
// End: memory read of the open slot, then update and write.
// Dump: walks all slots, emitting one beat per valid slot and skipping empty ones (EMPTY if none).
// One item in flight; the next beat is taken after its last result is accepted.
// Reset (aresetn low, synchronous) invalidates all slots and the open slot at once.
module wait_event_latency_stats_table_top #(
    parameter int TABLE_ENTRIES = 32
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cmd[1:0], event_id[33:2], timestamp[97:34], no_insert[98], close_event[99]
    input  logic [103:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[3:0], entry_id[35:4], occurrences[99:36], total_time[163:100],
    // longest_time[227:164]
    output logic [231:0] m_tdata,
    output logic         m_tlast
);
    import wels_pkg::*;

    ctl_t  ctl;
    stat_t stat;

    wels_ctrl #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .stat(stat), .ctl(ctl)
    );

    wels_datapath #(.TABLE_ENTRIES(TABLE_ENTRIES)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .ctl(ctl), .stat(stat), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
    );
endmodule

### src/wels_checker.sv
// Port-level checks for the statistics table top level, with bind.
// Depends on wait_event_latency_stats_table_top.
module wels_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_tvalid,
    input logic s_tready,
    input logic m_tvalid,
    input logic m_tready,
    input logic m_tlast
);
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid) else $error("result beat dropped");
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> !m_tvalid) else $error("ready with result pending");
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready) else $error("ready after accept");
    a_dump_cont: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !m_tlast |=> !s_tready) else $error("run ended early");
endmodule

bind wait_event_latency_stats_table_top wels_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tlast(m_tlast)
);

### verif/wait_event_latency_stats_table_top_tb.sv
// Testbench for the wait event latency statistics table: directed table, then random beats,
// each result beat checked against a behavioral table model. Depends on wels_pkg and the top.
`timescale 1ns / 1ps

module wait_event_latency_stats_table_top_tb;
    import wels_pkg::*;

    localparam int N = 32;

    typedef struct {
        logic [3:0]  status;
        logic [31:0] id;
        logic [63:0] cnt;
        logic [63:0] sum;
        logic [63:0] mx;
        logic        last;
    } stat_beat_t;

    typedef struct {
        logic [1:0]  cmd;
        logic [31:0] id;
        logic [63:0] ts;
        logic        noins;
        logic        close;
        logic        chk;
        logic [3:0]  status;
    } stim_t;

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [103:0] s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [231:0] m_tdata;
    logic         m_tlast;

    wait_event_latency_stats_table_top #(.TABLE_ENTRIES(N)) dut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // table model
    logic        tv[N];
    logic [31:0] tid[N];
    logic [63:0] tcnt[N], tsum[N], tmax[N];
    logic        op_v;
    int          op_s;
    logic [63:0] t0;

    stat_beat_t exp_q[$];
    int         errors = 0;
    int         n_items = 0, n_results = 0, n_dump_rows = 0;
    int         idle_cnt = 0;
    logic       done = 0;

    function automatic stat_beat_t mk(logic [3:0] st, logic [31:0] id, logic [63:0] c,
                                      logic [63:0] s, logic [63:0] m, logic l);
        stat_beat_t r;
        r.status = st; r.id = id; r.cnt = c; r.sum = s; r.mx = m; r.last = l;
        return r;
    endfunction

    task automatic predict_stats(input logic [1:0] cmd, input logic [31:0] id,
                                 input logic [63:0] ts, input logic noins, input logic close);
        int hit, fr, lastslot;
        logic [63:0] d;
        hit = N; fr = N; lastslot = N;
        case (cmd)
            CMD_START: begin
                if (id == 0) begin
                    exp_q.push_back(mk(ST_ZERO_ID, 0, 0, 0, 0, 1));
                    return;
                end
                for (int s = 0; s < N; s++) begin
                    if (tv[s]) begin
                        if (hit == N && tid[s] == id) hit = s;
                    end else if (fr == N) fr = s;
                end
                if (hit < N) tcnt[hit] += 1;
                else if (noins) begin
                    op_v = 0;
                    exp_q.push_back(mk(ST_MISS, id, 0, 0, 0, 1));
                    return;
                end else if (fr == N) begin
                    op_v = 0;
                    exp_q.push_back(mk(ST_FULL, id, 0, 0, 0, 1));
                    return;
                end else begin
                    hit = fr; tv[hit] = 1; tid[hit] = id;
                    tcnt[hit] = 1; tsum[hit] = 0; tmax[hit] = 0;
                end
                op_v = 1; op_s = hit; t0 = ts;
                exp_q.push_back(mk(ST_STARTED, tid[hit], tcnt[hit], tsum[hit], tmax[hit], 1));
            end
            CMD_END: begin
                if (!op_v) begin
                    exp_q.push_back(mk(ST_NONE_OPEN, 0, 0, 0, 0, 1));
                    return;
                end
                d = ts - t0;
                tsum[op_s] += d;
                if (tmax[op_s] < d) tmax[op_s] = d;
                exp_q.push_back(mk(ST_ENDED, tid[op_s], tcnt[op_s], tsum[op_s], tmax[op_s], 1));
                if (close) op_v = 0;
            end
            CMD_DUMP: begin
                for (int s = 0; s < N; s++) if (tv[s]) lastslot = s;
                if (lastslot == N) exp_q.push_back(mk(ST_EMPTY, 0, 0, 0, 0, 1));
                else for (int s = 0; s < N; s++) if (tv[s]) begin
                    exp_q.push_back(mk(ST_ENTRY, tid[s], tcnt[s], tsum[s], tmax[s],
                                       s == lastslot));
                    n_dump_rows++;
                end
                for (int s = 0; s < N; s++) tv[s] = 0;
                op_v = 0;
            end
            default: begin
                for (int s = 0; s < N; s++) tv[s] = 0;
                op_v = 0;
                exp_q.push_back(mk(ST_CLEARED, 0, 0, 0, 0, 1));
            end
        endcase
    endtask

    task automatic send_beat(input logic [1:0] cmd, input logic [31:0] id,
                             input logic [63:0] ts, input logic noins, input logic close);
        int gap;
        gap = $urandom_range(0, 7) * ($urandom_range(0, 3) != 0);
        if (gap > 0) begin
            s_tvalid <= 0;
            repeat (gap) @(posedge aclk);
        end
        s_tdata <= {4'b0, close, noins, ts, id, cmd};
        s_tvalid <= 1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        predict_stats(cmd, id, ts, noins, close);
        n_items++;
    endtask

    task automatic drain_results();
        s_tvalid <= 0;
        while (exp_q.size() != 0) @(posedge aclk);
    endtask

    // result side
    int stall = 0;
    always @(posedge aclk) begin
        stat_beat_t e;
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (exp_q.size() == 0) begin
                    $error("result beat with nothing expected: %h", m_tdata);
                    errors++;
                end else begin
                    e = exp_q.pop_front();
                    if (m_tdata[3:0] !== e.status) begin
                        $error("status exp %0d got %0d", e.status, m_tdata[3:0]); errors++;
                    end
                    if (m_tdata[35:4] !== e.id) begin
                        $error("entry_id exp %h got %h", e.id, m_tdata[35:4]); errors++;
                    end
                    if (m_tdata[99:36] !== e.cnt) begin
                        $error("occurrences exp %h got %h", e.cnt, m_tdata[99:36]); errors++;
                    end
                    if (m_tdata[163:100] !== e.sum) begin
                        $error("total_time exp %h got %h", e.sum, m_tdata[163:100]); errors++;
                    end
                    if (m_tdata[227:164] !== e.mx) begin
                        $error("longest_time exp %h got %h", e.mx, m_tdata[227:164]); errors++;
                    end
                    if (m_tlast !== e.last) begin
                        $error("last exp %0d got %0d", e.last, m_tlast); errors++;
                    end
                end
            end
            if (stall > 0) begin
                stall <= stall - 1;
                m_tready <= 0;
            end else if (m_tvalid && m_tready) begin
                if ($urandom_range(0, 3) == 0) begin
                    stall <= $urandom_range(0, 7);
                    m_tready <= 0;
                end else m_tready <= 1;
            end else m_tready <= 1;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cnt <= 0;
        else idle_cnt <= idle_cnt + 1;
        if (idle_cnt > 2000 && !done) begin
            $display("wait_event_latency_stats_table_top_tb NOT OK");
            $finish;
        end
    end

    stim_t dir[$];

    function automatic stim_t row(logic [1:0] c, logic [31:0] id, logic [63:0] ts,
                                  logic ni, logic cl, logic chk, logic [3:0] st);
        stim_t r;
        r.cmd = c; r.id = id; r.ts = ts; r.noins = ni; r.close = cl; r.chk = chk;
        r.status = st;
        return r;
    endfunction

    initial begin
        logic [31:0] ids[8];
        logic [63:0] now;
        int k;
        for (int s = 0; s < N; s++) begin
            tv[s] = 0; tid[s] = 0; tcnt[s] = 0; tsum[s] = 0; tmax[s] = 0;
        end
        op_v = 0; op_s = 0; t0 = 0;
        // directed: expected status typed where obvious
        dir.push_back(row(CMD_DUMP, 0, 0, 0, 0, 1, ST_EMPTY));
        dir.push_back(row(CMD_END, 0, 5, 0, 0, 1, ST_NONE_OPEN));
        dir.push_back(row(CMD_START, 0, 5, 0, 0, 1, ST_ZERO_ID));
        dir.push_back(row(CMD_START, 32'h1234, 0, 1, 0, 1, ST_MISS));
        dir.push_back(row(CMD_START, 32'hFFFF_FFFF, 64'd100, 0, 0, 1, ST_STARTED));
        dir.push_back(row(CMD_END, 32'hFFFF_FFFF, 64'd50, 0, 0, 1, ST_ENDED));
        dir.push_back(row(CMD_END, 0, 64'hFFFF_FFFF_FFFF_FFFF, 0, 1, 1, ST_ENDED));
        dir.push_back(row(CMD_END, 0, 64'd7, 0, 1, 1, ST_NONE_OPEN));
        dir.push_back(row(CMD_START, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 1, 0, 1,
                          ST_STARTED));
        dir.push_back(row(CMD_END, 0, 64'd3, 1, 1, 1, ST_ENDED));
        dir.push_back(row(CMD_START, 32'h1, 64'd10, 0, 0, 1, ST_STARTED));
        dir.push_back(row(CMD_START, 32'h2, 64'd20, 0, 0, 0, 0));
        dir.push_back(row(CMD_END, 0, 64'd25, 0, 1, 0, 0));
        dir.push_back(row(CMD_DUMP, 0, 0, 0, 0, 0, 0));
        dir.push_back(row(CMD_DUMP, 0, 0, 0, 0, 1, ST_EMPTY));
        dir.push_back(row(CMD_START, 32'h5, 64'd1, 0, 0, 1, ST_STARTED));
        dir.push_back(row(CMD_CLEAR, 0, 0, 0, 0, 1, ST_CLEARED));
        dir.push_back(row(CMD_END, 0, 0, 0, 0, 1, ST_NONE_OPEN));
        for (int i = 0; i < N; i++)
            dir.push_back(row(CMD_START, 32'h100 + i, i, 0, 0, 0, 0));
        dir.push_back(row(CMD_START, 32'h999, 64'd9, 0, 0, 1, ST_FULL));
        dir.push_back(row(CMD_END, 0, 64'd9, 0, 0, 1, ST_NONE_OPEN));
        dir.push_back(row(CMD_DUMP, 0, 0, 0, 0, 0, 0));

        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        foreach (dir[i]) begin
            send_beat(dir[i].cmd, dir[i].id, dir[i].ts, dir[i].noins, dir[i].close);
            if (dir[i].chk && exp_q[$].status !== dir[i].status) begin
                $error("status exp %0d got %0d (table row %0d)", dir[i].status,
                       exp_q[$].status, i);
                errors++;
            end
        end
        drain_results();

        // random: well-formed start/end pairs over a small id pool, plus noise
        for (int i = 0; i < 8; i++) ids[i] = $urandom();
        ids[0] = 32'hFFFF_FFFF;
        ids[1] = 32'h1;
        now = {$urandom(), $urandom()};
        k = 0;
        while (k < 200) begin
            if (k == 100) drain_results();
            case ($urandom_range(0, 19))
                0: send_beat(CMD_DUMP, $urandom(), {$urandom(), $urandom()},
                             $urandom_range(0, 1), $urandom_range(0, 1));
                1: send_beat(CMD_CLEAR, $urandom(), {$urandom(), $urandom()},
                             $urandom_range(0, 1), $urandom_range(0, 1));
                2: send_beat(CMD_START, ($urandom_range(0, 1) ? 32'h0 : $urandom()),
                             {$urandom(), $urandom()}, $urandom_range(0, 1), 0);
                3: send_beat(CMD_END, $urandom(), {$urandom(), $urandom()},
                             $urandom_range(0, 1), $urandom_range(0, 1));
                default: begin
                    send_beat(CMD_START, ids[$urandom_range(0, 7)], now,
                              ($urandom_range(0, 4) == 0), $urandom_range(0, 1));
                    now += ($urandom_range(0, 7) == 0) ? {$urandom(), $urandom()}
                                                       : $urandom_range(0, 5000);
                    send_beat(CMD_END, $urandom(), now, $urandom_range(0, 1),
                              ($urandom_range(0, 3) != 0));
                    k++;
                end
            endcase
            k++;
        end
        send_beat(CMD_DUMP, 0, 0, 0, 0);
        drain_results();
        done = 1;
        repeat (200) @(posedge aclk);
        if (m_tvalid) begin
            $error("result beat pending after the end of stimulus");
            errors++;
        end
        $display("Covered %0d input beats, %0d result beats, %0d dump rows.",
                 n_items, n_results, n_dump_rows);
        if (errors == 0) begin
            $display("wait_event_latency_stats_table_top_tb OK");
        end else begin
            $display("wait_event_latency_stats_table_top_tb NOT OK");
        end
        $finish;
    end
endmodule

### filelist.f
src/wels_pkg.sv
src/wels_datapath.sv
src/wels_ctrl.sv
src/wait_event_latency_stats_table_top.sv
src/wels_checker.sv
verif/wait_event_latency_stats_table_top_tb.sv
